FILE: rtl/assert_macros.svh
// Assertion shorthands shared by the RTL.
// Each macro takes a label, a clock, an active-low reset and the checked expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
		else $error("assertion failed: invariant");

// When the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/wptm_pkg.sv
package wptm_pkg;

	localparam int DEPTH_DEF = 64;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;

	typedef struct packed {
		logic [7:0] key_class;
		logic [7:0] key_slot;
		logic [7:0] key_level;
	} key_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  key_class;
		logic [7:0]  key_slot;
		logic [7:0]  key_level;
		logic [31:0] rule_value;
	} req_word_t;

	typedef struct packed {
		logic [31:0] match_value;
		logic        matched;
		logic        append_dropped;
	} rsp_word_t;

	// One stored rule: keys above, value below.
	typedef struct packed {
		key_t        keys;
		logic [31:0] value;
	} rule_t;

	localparam int RULE_W = $bits(rule_t);

	// Control from the sequencer to the match unit.
	typedef struct packed {
		logic start;    // new lookup: forget the previous best
		logic valid;    // read data from the table is present this cycle
	} scan_ctrl_t;

endpackage

FILE: rtl/wptm_ram.sv
module wptm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/wptm_scan.sv
module wptm_scan import wptm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  scan_ctrl_t  ctrl,
	input  key_t        query,
	input  rule_t       rule,
	output logic [31:0] best_value,
	output logic        found
);

	logic       hit;
	logic [2:0] score;
	logic [2:0] best_score_q;
	logic       found_q;
	logic [31:0] best_value_q;

	// A rule key of zero is a wildcard and matches anything.
	always_comb begin
		hit = (rule.keys.key_class == 8'd0 || rule.keys.key_class == query.key_class)
			&& (rule.keys.key_slot == 8'd0 || rule.keys.key_slot == query.key_slot)
			&& (rule.keys.key_level == 8'd0 || rule.keys.key_level == query.key_level);
		score = {rule.keys.key_class != 8'd0, rule.keys.key_slot != 8'd0,
			rule.keys.key_level != 8'd0};
	end

	// Strictly greater replaces, so the earliest rule keeps a tie.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctrl.start) begin
			found_q <= 1'b0;
		end else if (ctrl.valid && hit) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			best_value_q <= 32'd0;
			best_score_q <= 3'd0;
		end else if (ctrl.valid && hit && (!found_q || score > best_score_q)) begin
			best_value_q <= rule.value;
			best_score_q <= score;
		end
	end

	assign best_value = best_value_q;
	assign found      = found_q;

endmodule

FILE: rtl/wildcard_priority_table_match_unit.sv
// Wildcard rule table with most-specific match. Each request word clears the table, appends a
// rule of three 8-bit keys and a 32-bit value, or looks up a key triple; every request gives
// exactly one response word. A rule key of zero is a wildcard. A lookup returns the value of the
// matching rule with the highest score (4 for a set class key, 2 for slot, 1 for level), the
// earliest such rule on a tie, or zero with matched low if nothing matches. An append to a full
// table is refused and flagged with append_dropped. Clear, append and a lookup on an empty
// table are answered directly. Any other lookup reads the stored rules one per cycle through
// the single read port of the rule memory, lets the last read pass the memory's read register,
// and posts the result once the response register is free; only then is a new request taken.
// Requests are taken one at a time, so a lookup never overlaps a write to the table. No
// clearing pass is needed after reset: only entries below the rule count are ever read.
`include "assert_macros.svh"

module wildcard_priority_table_match_unit import wptm_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_word_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_word_t rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]    state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] addr_q;
	key_t          query_q;
	logic          rd_vld_s1;
	logic          rsp_valid_q;
	rsp_word_t     rsp_word_q;

	logic       req_fire;
	logic       rsp_free;
	logic       full;
	logic       last_addr;
	logic       rsp_load;
	rsp_word_t  rsp_next;
	logic       wr_en;
	rule_t      wr_rule;
	rule_t      rd_rule;
	scan_ctrl_t scan_ctrl;
	logic [31:0] best_value;
	logic        found;

	// The response register may take a new word when empty or when its word leaves now.
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE) || !rsp_free;
	assign req_fire  = req_valid && !req_stall;
	assign full      = (count_q == CW'(DEPTH));
	assign last_addr = (addr_q == count_q - CW'(1));

	assign wr_en   = req_fire && req.opcode == OP_APPEND && !full;
	assign wr_rule = '{keys: '{key_class: req.key_class, key_slot: req.key_slot,
		key_level: req.key_level}, value: req.rule_value};

	wptm_ram #(
		.WIDTH (RULE_W),
		.DEPTH (DEPTH)
	) u_rules (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (wr_rule),
		.rd_en   (state_q == ST_SCAN),
		.rd_addr (addr_q[AW-1:0]),
		.rd_data (rd_rule)
	);

	assign scan_ctrl = '{start: req_fire && req.opcode == OP_LOOKUP, valid: rd_vld_s1};

	wptm_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (scan_ctrl),
		.query      (query_q),
		.rule       (rd_rule),
		.best_value (best_value),
		.found      (found)
	);

	// Response word to post this cycle, if any.
	always_comb begin
		rsp_load = 1'b0;
		rsp_next = '0;
		if (req_fire) begin
			case (req.opcode)
				OP_APPEND: begin
					rsp_load = 1'b1;
					rsp_next.append_dropped = full;
				end
				OP_LOOKUP: begin
					// An empty table answers at once with no match.
					rsp_load = (count_q == CW'(0));
				end
				default: begin
					rsp_load = 1'b1;
				end
			endcase
		end else if (state_q == ST_DONE && rsp_free) begin
			rsp_load = 1'b1;
			rsp_next.match_value = best_value;
			rsp_next.matched     = found;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			addr_q      <= '0;
			rd_vld_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						case (req.opcode)
							OP_CLEAR: begin
								count_q <= '0;
							end
							OP_APPEND: begin
								if (!full) begin
									count_q <= count_q + CW'(1);
								end
							end
							OP_LOOKUP: begin
								addr_q <= '0;
								if (count_q != CW'(0)) begin
									state_q <= ST_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					addr_q <= addr_q + CW'(1);
					if (last_addr) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				default: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_word_q <= rsp_next;
		end
		if (req_fire) begin
			query_q <= '{key_class: req.key_class, key_slot: req.key_slot,
				key_level: req.key_level};
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_word_q;

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CW'(DEPTH))
	`ASSERT_IMPLIES(a_scan_in_range, clk, arst_n, state_q == ST_SCAN, addr_q < count_q)
	`ASSERT_NEXT(a_append_grows, clk, arst_n,
		req_fire && req.opcode == OP_APPEND && !full, count_q == $past(count_q) + CW'(1))
	`ASSERT_NEXT(a_drop_keeps_count, clk, arst_n,
		req_fire && req.opcode == OP_APPEND && full, count_q == $past(count_q))
	`ASSERT_IMPLIES(a_match_not_drop, clk, arst_n, rsp_valid_q && rsp_word_q.matched,
		!rsp_word_q.append_dropped)

endmodule

FILE: sim/wptm_match_checker.sv
module wptm_match_checker import wptm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_stall,
	input  req_word_t req,
	input  logic      rsp_valid,
	input  logic      rsp_stall,
	input  rsp_word_t rsp,
	output int        errors,
	output int        awaited,
	output int        lookups,
	output int        hits,
	output int        drops
);

	localparam int         CLASS_WEIGHT = 4;
	localparam int         SLOT_WEIGHT  = 2;
	localparam int         LEVEL_WEIGHT = 1;
	localparam int         REPORT_MAX   = 10;
	localparam logic [7:0] WILDCARD     = 8'd0;

	// Private copy of the rule table, filled from accepted request words.
	rule_t       rules [DEPTH_DEF];
	int unsigned rule_total;
	rsp_word_t   expected_rsp [$];
	rsp_word_t   want;

	function automatic logic key_hits(input logic [7:0] rule_key, input logic [7:0] probe);
		return rule_key == WILDCARD || rule_key == probe;
	endfunction

	// Updates the table copy and returns the response word the request should give.
	function automatic rsp_word_t best_rule_response(input req_word_t w);
		rsp_word_t r;
		key_t      k;
		int        best;
		int        score;
		int        i;
		r = '0;
		best = -1;
		case (w.opcode)
			OP_CLEAR: begin
				rule_total = 0;
			end
			OP_APPEND: begin
				if (rule_total < DEPTH_DEF) begin
					rules[rule_total] = {w.key_class, w.key_slot, w.key_level, w.rule_value};
					rule_total++;
				end else begin
					r.append_dropped = 1'b1;
				end
			end
			OP_LOOKUP: begin
				for (i = 0; i < rule_total; i++) begin
					k = rules[i].keys;
					if (key_hits(k.key_class, w.key_class) && key_hits(k.key_slot, w.key_slot)
							&& key_hits(k.key_level, w.key_level)) begin
						score = (k.key_class != WILDCARD ? CLASS_WEIGHT : 0)
							+ (k.key_slot != WILDCARD ? SLOT_WEIGHT : 0)
							+ (k.key_level != WILDCARD ? LEVEL_WEIGHT : 0);
						// Strictly greater, so the earliest rule keeps a tie.
						if (score > best) begin
							best = score;
							r.match_value = rules[i].value;
						end
					end
				end
				r.matched = best >= 0;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_total = 0;
			expected_rsp.delete();
			awaited <= 0;
		end else begin
			// Requests first, so a response in the same cycle still finds its word.
			if (req_valid && !req_stall) begin
				want = best_rule_response(req);
				expected_rsp = {expected_rsp, want};
				if (req.opcode == OP_LOOKUP) begin
					lookups++;
				end
				hits += want.matched;
				drops += want.append_dropped;
			end
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp.size() == 0) begin
					if (errors < REPORT_MAX) begin
						$display("%0t: response word with nothing outstanding:", $realtime,
							" value %h matched %b dropped %b",
							rsp.match_value, rsp.matched, rsp.append_dropped);
					end
					errors++;
				end else begin
					want = expected_rsp.pop_front();
					if (rsp.match_value !== want.match_value || rsp.matched !== want.matched
							|| rsp.append_dropped !== want.append_dropped) begin
						if (errors < REPORT_MAX) begin
							$display("%0t: mismatch: expected value %h matched %b dropped %b,",
								$realtime, want.match_value, want.matched,
								want.append_dropped, " got value %h matched %b dropped %b",
								rsp.match_value, rsp.matched, rsp.append_dropped);
						end
						errors++;
					end
				end
			end
			awaited <= expected_rsp.size();
		end
	end

endmodule

FILE: sim/wildcard_priority_table_match_unit_tb.sv
// Testbench for the wildcard rule table. The top only produces request words and stalls on the
// response channel; a separate checker watches both channels, keeps its own copy of the rule
// table and compares every response word with the one it predicts.
module wildcard_priority_table_match_unit_tb;
	import wptm_pkg::*;

	// Opcode three is not used by the block; it must leave the table alone.
	localparam logic [1:0] OP_UNUSED     = 2'd3;
	localparam int         TARGET_WORDS  = 750;
	localparam int         CYCLE_LIMIT   = 1000000;
	localparam int         SETTLE_CYCLES = 16;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_word_t req       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_word_t rsp;

	int errors;
	int awaited;
	int lookups;
	int hits;
	int drops;

	// Counted request words, noise words with the unused opcode, and the cycle count.
	int   real_words = 0;
	int   noise_words = 0;
	int   cycles = 0;
	int   stall_left = 0;
	logic quiet = 1'b0;

	// Keys appended since the last clear; lookups mostly aim at these.
	key_t shelf [$];

	always #5 clk = ~clk;

	wildcard_priority_table_match_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	wptm_match_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.errors    (errors),
		.awaited   (awaited),
		.lookups   (lookups),
		.hits      (hits),
		.drops     (drops)
	);

	// Idle lengths: mostly none or short, now and then a long one. In a quiet stretch
	// neither side idles at all.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// The response side alternates between runs of stalling and runs of taking words.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else begin
			rsp_stall <= !quiet && ($urandom_range(0, 2) == 0);
			stall_left <= idle_len();
		end
	end

	// A run that hangs is ended here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Presents one request word after an optional gap and returns at the edge where it is taken.
	// With no gap the valid stays high, so it is never lowered and raised in the same step.
	task automatic send_word(input logic [1:0] op, input logic [7:0] c, input logic [7:0] s,
			input logic [7:0] l, input logic [31:0] v);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= '{opcode: op, key_class: c, key_slot: s, key_level: l, rule_value: v};
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		if (op == OP_UNUSED) begin
			noise_words++;
		end else begin
			real_words++;
		end
	endtask

	// Holds the request side until every outstanding response word has come back. The first
	// edge lets the checker's count take in a word accepted at the current edge.
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (awaited != 0) @(posedge clk);
	endtask

	// Rule keys lean on wildcards and a few small values so that rules overlap.
	function automatic logic [7:0] rule_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			return 8'd0;
		end
		if (r < 85) begin
			return 8'($urandom_range(1, 3));
		end
		return 8'($urandom_range(1, 255));
	endfunction

	// A lookup key mostly repeats a stored key, otherwise it is zero, small or anything.
	function automatic logic [7:0] probe_key(input logic [7:0] seen);
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return seen;
		end
		if (r < 70) begin
			return 8'd0;
		end
		if (r < 90) begin
			return 8'($urandom_range(1, 3));
		end
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic add_rule();
		key_t k;
		k = '{key_class: rule_key(), key_slot: rule_key(), key_level: rule_key()};
		send_word(OP_APPEND, k.key_class, k.key_slot, k.key_level, $urandom());
		shelf = {shelf, k};
	endtask

	task automatic probe();
		key_t k;
		if (shelf.size() != 0 && $urandom_range(0, 9) != 0) begin
			k = shelf[$urandom_range(0, shelf.size() - 1)];
		end else begin
			k = '{key_class: 8'($urandom()), key_slot: 8'($urandom()), key_level: 8'($urandom())};
		end
		send_word(OP_LOOKUP, probe_key(k.key_class), probe_key(k.key_slot),
			probe_key(k.key_level), $urandom());
	endtask

	task automatic maybe_noise();
		if ($urandom_range(0, 19) == 0) begin
			send_word(OP_UNUSED, 8'($urandom()), 8'($urandom()), 8'($urandom()), $urandom());
		end
	endtask

	initial begin : stimulus
		int seq;
		int n_append;
		int n_probe;
		int i;
		seq = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words. A lookup on the empty table must miss, and the unused opcode with
		// every bit set must change nothing.
		send_word(OP_LOOKUP, 8'h01, 8'h02, 8'h03, 32'h0);
		send_word(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
		// A catch-all rule whose value is zero: a hit that still reads zero.
		send_word(OP_APPEND, 8'h00, 8'h00, 8'h00, 32'h0);
		send_word(OP_LOOKUP, 8'h00, 8'h00, 8'h00, 32'hFFFF_FFFF);
		send_word(OP_LOOKUP, 8'hFF, 8'hFF, 8'hFF, 32'h0);
		// One rule per weight, a tie on the class key, the all-ones rule and the exact rule.
		send_word(OP_APPEND, 8'h00, 8'h00, 8'h07, 32'h0000_00A1);
		send_word(OP_APPEND, 8'h00, 8'h05, 8'h00, 32'h0000_00B2);
		send_word(OP_APPEND, 8'h09, 8'h00, 8'h00, 32'h0000_00C4);
		send_word(OP_APPEND, 8'h09, 8'h00, 8'h00, 32'h0000_00D4);
		send_word(OP_APPEND, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
		send_word(OP_APPEND, 8'h09, 8'h05, 8'h07, 32'h0000_00E7);
		send_word(OP_LOOKUP, 8'h09, 8'h05, 8'h07, 32'h0);
		send_word(OP_LOOKUP, 8'h09, 8'h05, 8'h08, 32'h0);
		send_word(OP_LOOKUP, 8'h01, 8'h05, 8'h07, 32'h0);
		send_word(OP_LOOKUP, 8'h01, 8'h01, 8'h07, 32'h0);
		send_word(OP_LOOKUP, 8'hFF, 8'hFF, 8'hFF, 32'h0);
		send_word(OP_LOOKUP, 8'h00, 8'h05, 8'h00, 32'h0);
		// Clear with every field set, after which nothing matches.
		send_word(OP_CLEAR, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
		send_word(OP_LOOKUP, 8'h09, 8'h05, 8'h07, 32'h0);
		send_word(OP_APPEND, 8'h80, 8'h01, 8'hAA, 32'h8000_0001);
		send_word(OP_LOOKUP, 8'h80, 8'h01, 8'hAA, 32'h0);
		send_word(OP_CLEAR, 8'h00, 8'h00, 8'h00, 32'h0);
		drain();

		// Random part: mostly a clear, a batch of appends with lookups mixed in, then lookups.
		// The first batch and an occasional later one may overfill the table so that appends are
		// refused; sometimes the clear is left out and the table keeps growing.
		while (real_words < TARGET_WORDS) begin
			quiet <= ($urandom_range(0, 4) == 0);
			if (seq == 0 || $urandom_range(0, 9) != 0) begin
				send_word(OP_CLEAR, 8'($urandom()), 8'($urandom()), 8'($urandom()), $urandom());
				shelf.delete();
			end
			if (seq == 0 || $urandom_range(0, 11) == 0) begin
				n_append = $urandom_range(DEPTH_DEF - 4, DEPTH_DEF + 8);
			end else begin
				n_append = $urandom_range(0, 12);
			end
			n_probe = $urandom_range(1, 10);
			for (i = 0; i < n_append; i++) begin
				maybe_noise();
				add_rule();
				if ($urandom_range(0, 6) == 0) begin
					probe();
				end
			end
			for (i = 0; i < n_probe; i++) begin
				maybe_noise();
				probe();
			end
			if (seq % 10 == 9) begin
				drain();
			end
			seq++;
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d request words and %0d words with the unused opcode over %0d batches.",
			real_words, noise_words, seq);
		$display("Of %0d lookups %0d found a rule; %0d appends were refused on a full table.",
			lookups, hits, drops);
		if (errors == 0 && awaited == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
